### design/tadc_pkg.sv
package tadc_pkg;

   // coordinate handling
   localparam int CoordBits = 12;
   localparam int PenBits   = 12;
   localparam int ScaleBits = 10;
   localparam int NumBits   = PenBits + ScaleBits;
   localparam int StepBits  = $clog2(NumBits);
   localparam int DivBits   = 13;
   localparam int SampleBits = 16;

   localparam logic [PenBits-1:0]   CoordMask = PenBits'((64'd1 << CoordBits) - 64'd1);
   localparam logic [ScaleBits-1:0] XScale    = 10'd875;
   localparam logic [ScaleBits-1:0] YScale    = 10'd870;
   localparam logic [ScaleBits-1:0] XBase     = 10'd90;
   localparam logic [ScaleBits-1:0] YBase     = 10'd920;
   localparam logic [StepBits-1:0]  StepLast  = StepBits'(NumBits - 1);

   // register bits
   localparam logic [31:0] StartBit = 32'h0000_0001;
   localparam logic [31:0] EndFlag  = 32'h0000_8000;
   localparam logic [31:0] DpstMask = 32'h0000_3000;
   localparam logic [31:0] UpFlag   = 32'h0000_8000;
   localparam int          PstShift = 12;

   // register offsets
   localparam logic [7:0] OFF_CONTROL = 8'd0;
   localparam logic [7:0] OFF_TOUCH   = 8'd4;
   localparam logic [7:0] OFF_DELAY   = 8'd8;
   localparam logic [7:0] OFF_DATA0   = 8'd12;
   localparam logic [7:0] OFF_DATA1   = 8'd16;

   // configuration register indexes
   localparam int CsrIndexBits = 4;
   localparam logic [CsrIndexBits-1:0] CSR_SCREEN_WIDTH  = 4'd0;
   localparam logic [CsrIndexBits-1:0] CSR_SCREEN_HEIGHT = 4'd1;

   localparam logic [DivBits-1:0] WidthReset  = 13'd240;
   localparam logic [DivBits-1:0] HeightReset = 13'd320;

   // item commands
   typedef enum logic [2:0] {
      CMD_READ  = 3'd0,
      CMD_WRITE = 3'd1,
      CMD_DOWN  = 3'd2,
      CMD_MOVE  = 3'd3,
      CMD_UP    = 3'd4,
      CMD_LOST  = 3'd5
   } cmd_type;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_EXEC  = 5'b00010,
      ST_MUL   = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_STORE = 5'b10000
   } state_type;

   // data0 after a pen state change
   function automatic logic [31:0] pen_data0(input logic [31:0] data0,
                                             input logic [31:0] touch_ctl,
                                             input logic up);
      logic [31:0] pst;
      pst = (touch_ctl & 32'h0000_0003) << PstShift;
      return (data0 & ~(DpstMask | UpFlag)) | pst | (up ? UpFlag : 32'd0);
   endfunction

   // data1 after a pen state change
   function automatic logic [31:0] pen_data1(input logic [31:0] data1, input logic up);
      return (data1 & ~UpFlag) | (up ? UpFlag : 32'd0);
   endfunction

endpackage

### design/touch_adc_register_block.sv
// Touch-panel ADC register block. An item is taken when start is high and busy
// is low; its single result appears one cycle with rsp_strobe, and the receiver
// cannot stall it, so it must be captured in that cycle. For register reads and
// writes, pen events that take no sample and capture-lost events, the strobe is
// registered from the EXEC state. A pen event that takes a sample goes through
// MUL, DIV and STORE per axis: the scaling runs x and then y through one shared
// multiplier and one restoring divider: one quotient bit per cycle, 22 per axis.
// The screen size registers are written through the csr_ port, which is always
// ready and must only be used while the block is idle.
module touch_adc_register_block (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [7:0]  req_reg_offset,
   input  logic [31:0] req_write_data,
   input  logic [11:0] req_pen_x,
   input  logic [11:0] req_pen_y,
   output logic        rsp_strobe,
   output logic [31:0] rsp_read_data,
   output logic        rsp_touch_irq,
   output logic        rsp_bad_access,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [tadc_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [tadc_pkg::DivBits-1:0]      csr_wdata
);

   tadc_pkg::state_type state_ff, state_in;

   logic [tadc_pkg::DivBits-1:0]    width_ff, width_in;
   logic [tadc_pkg::DivBits-1:0]    height_ff, height_in;
   logic [31:0] control_ff, control_in;
   logic [31:0] touch_ff, touch_in;
   logic [31:0] delay_ff, delay_in;
   logic [31:0] data0_ff, data0_in;
   logic [31:0] data1_ff, data1_in;
   logic [tadc_pkg::SampleBits-1:0] sample_x_ff, sample_x_in;
   logic [tadc_pkg::SampleBits-1:0] sample_y_ff, sample_y_in;

   logic [2:0]  cmd_ff, cmd_in;
   logic [7:0]  offset_ff, offset_in;
   logic [31:0] wdata_ff, wdata_in;
   logic [tadc_pkg::PenBits-1:0] pen_x_ff, pen_x_in;
   logic [tadc_pkg::PenBits-1:0] pen_y_ff, pen_y_in;

   logic                            axis_ff, axis_in;
   logic [tadc_pkg::NumBits-1:0]    num_ff, num_in;
   logic [tadc_pkg::DivBits-1:0]    rem_ff, rem_in;
   logic [tadc_pkg::StepBits-1:0]   step_ff, step_in;

   logic        rsp_strobe_ff, rsp_strobe_in;
   logic [31:0] rsp_read_data_ff, rsp_read_data_in;
   logic        rsp_touch_irq_ff, rsp_touch_irq_in;
   logic        rsp_bad_access_ff, rsp_bad_access_in;

   logic [tadc_pkg::DivBits-1:0]   divisor;
   logic [tadc_pkg::DivBits:0]     trial;
   logic [tadc_pkg::NumBits:0]     x_sum;
   logic [tadc_pkg::ScaleBits-1:0] y_diff;

   assign busy      = (state_ff != tadc_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_read_data  = rsp_read_data_ff;
   assign rsp_touch_irq  = rsp_touch_irq_ff;
   assign rsp_bad_access = rsp_bad_access_ff;

   // divider datapath, zero divisor acts as one
   always_comb begin
      divisor = axis_ff ? height_ff : width_ff;
      if (divisor == '0) begin
         divisor = tadc_pkg::DivBits'(1);
      end
      trial  = {rem_ff, num_ff[tadc_pkg::NumBits-1]};
      x_sum  = {1'b0, num_ff} + (tadc_pkg::NumBits+1)'(tadc_pkg::XBase);
      y_diff = tadc_pkg::YBase - num_ff[tadc_pkg::ScaleBits-1:0];
   end

   // sequencer and register update
   always_comb begin
      state_in    = state_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      control_in  = control_ff;
      touch_in    = touch_ff;
      delay_in    = delay_ff;
      data0_in    = data0_ff;
      data1_in    = data1_ff;
      sample_x_in = sample_x_ff;
      sample_y_in = sample_y_ff;
      cmd_in      = cmd_ff;
      offset_in   = offset_ff;
      wdata_in    = wdata_ff;
      pen_x_in    = pen_x_ff;
      pen_y_in    = pen_y_ff;
      axis_in     = axis_ff;
      num_in      = num_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      rsp_strobe_in     = 1'b0;
      rsp_read_data_in  = '0;
      rsp_touch_irq_in  = 1'b0;
      rsp_bad_access_in = 1'b0;

      // configuration writes
      if (csr_valid) begin
         if (csr_index == tadc_pkg::CSR_SCREEN_WIDTH) begin
            width_in = csr_wdata;
         end else if (csr_index == tadc_pkg::CSR_SCREEN_HEIGHT) begin
            height_in = csr_wdata;
         end
      end

      unique case (state_ff)
         tadc_pkg::ST_IDLE: begin
            if (start) begin
               cmd_in    = req_cmd;
               offset_in = req_reg_offset;
               wdata_in  = req_write_data;
               pen_x_in  = req_pen_x & tadc_pkg::CoordMask;
               pen_y_in  = req_pen_y & tadc_pkg::CoordMask;
               state_in  = tadc_pkg::ST_EXEC;
            end
         end

         tadc_pkg::ST_EXEC: begin
            state_in = tadc_pkg::ST_IDLE;
            axis_in  = 1'b0;
            unique case (cmd_ff)
               tadc_pkg::CMD_READ: begin
                  rsp_strobe_in = 1'b1;
                  unique case (offset_ff)
                     tadc_pkg::OFF_CONTROL: rsp_read_data_in = control_ff;
                     tadc_pkg::OFF_TOUCH:   rsp_read_data_in = touch_ff;
                     tadc_pkg::OFF_DELAY:   rsp_read_data_in = delay_ff;
                     tadc_pkg::OFF_DATA0:   rsp_read_data_in = data0_ff;
                     tadc_pkg::OFF_DATA1:   rsp_read_data_in = data1_ff;
                     default:               rsp_bad_access_in = 1'b1;
                  endcase
               end
               tadc_pkg::CMD_WRITE: begin
                  rsp_strobe_in = 1'b1;
                  unique case (offset_ff)
                     tadc_pkg::OFF_CONTROL: begin
                        if ((wdata_ff & tadc_pkg::StartBit) != '0) begin
                           // conversion start: latch samples with axes swapped
                           control_in = (wdata_ff & ~tadc_pkg::StartBit) | tadc_pkg::EndFlag;
                           data0_in   = {data0_ff[31:10], sample_y_ff[9:0]};
                           data1_in   = {data1_ff[31:10], sample_x_ff[9:0]};
                        end else begin
                           control_in = wdata_ff;
                        end
                     end
                     tadc_pkg::OFF_TOUCH: touch_in = wdata_ff;
                     tadc_pkg::OFF_DELAY: delay_in = wdata_ff;
                     tadc_pkg::OFF_DATA0, tadc_pkg::OFF_DATA1: begin
                     end
                     default: rsp_bad_access_in = 1'b1;
                  endcase
               end
               tadc_pkg::CMD_DOWN: begin
                  // pen goes down first, so the guard sees the new state
                  data0_in = tadc_pkg::pen_data0(data0_ff, touch_ff, 1'b0);
                  data1_in = tadc_pkg::pen_data1(data1_ff, 1'b0);
                  if (touch_ff[1:0] != 2'b00) begin
                     state_in = tadc_pkg::ST_MUL;
                  end else begin
                     rsp_strobe_in    = 1'b1;
                     rsp_touch_irq_in = 1'b1;
                  end
               end
               tadc_pkg::CMD_MOVE, tadc_pkg::CMD_UP: begin
                  if ((data0_ff[13:12] != 2'b00) && !data0_ff[15]) begin
                     state_in = tadc_pkg::ST_MUL;
                  end else begin
                     rsp_strobe_in = 1'b1;
                     if (cmd_ff == tadc_pkg::CMD_UP) begin
                        data0_in = tadc_pkg::pen_data0(data0_ff, touch_ff, 1'b1);
                        data1_in = tadc_pkg::pen_data1(data1_ff, 1'b1);
                        rsp_touch_irq_in = 1'b1;
                     end
                  end
               end
               tadc_pkg::CMD_LOST: begin
                  rsp_strobe_in = 1'b1;
                  if (!data0_ff[15]) begin
                     data0_in = tadc_pkg::pen_data0(data0_ff, touch_ff, 1'b1);
                     data1_in = tadc_pkg::pen_data1(data1_ff, 1'b1);
                     rsp_touch_irq_in = 1'b1;
                  end
               end
               default: rsp_strobe_in = 1'b1;
            endcase
         end

         // scaled coordinate product for the current axis
         tadc_pkg::ST_MUL: begin
            if (axis_ff) begin
               num_in = {tadc_pkg::ScaleBits'(0), pen_y_ff}
                      * {tadc_pkg::PenBits'(0), tadc_pkg::YScale};
            end else begin
               num_in = {tadc_pkg::ScaleBits'(0), pen_x_ff}
                      * {tadc_pkg::PenBits'(0), tadc_pkg::XScale};
            end
            rem_in   = '0;
            step_in  = '0;
            state_in = tadc_pkg::ST_DIV;
         end

         // one restoring division step, quotient shifts into num
         tadc_pkg::ST_DIV: begin
            if (trial >= {1'b0, divisor}) begin
               rem_in = tadc_pkg::DivBits'(trial - {1'b0, divisor});
               num_in = {num_ff[tadc_pkg::NumBits-2:0], 1'b1};
            end else begin
               rem_in = trial[tadc_pkg::DivBits-1:0];
               num_in = {num_ff[tadc_pkg::NumBits-2:0], 1'b0};
            end
            step_in = step_ff + tadc_pkg::StepBits'(1);
            if (step_ff == tadc_pkg::StepLast) begin
               state_in = tadc_pkg::ST_STORE;
            end
         end

         // offset and clamp the quotient, then next axis or finish the item
         tadc_pkg::ST_STORE: begin
            if (!axis_ff) begin
               if (x_sum > (tadc_pkg::NumBits+1)'(16'hFFFF)) begin
                  sample_x_in = 16'hFFFF;
               end else begin
                  sample_x_in = x_sum[tadc_pkg::SampleBits-1:0];
               end
               axis_in  = 1'b1;
               state_in = tadc_pkg::ST_MUL;
            end else begin
               if (num_ff >= tadc_pkg::NumBits'(tadc_pkg::YBase)) begin
                  sample_y_in = '0;
               end else begin
                  sample_y_in = {(tadc_pkg::SampleBits-tadc_pkg::ScaleBits)'(0), y_diff};
               end
               rsp_strobe_in    = 1'b1;
               rsp_touch_irq_in = (cmd_ff != tadc_pkg::CMD_MOVE);
               if (cmd_ff == tadc_pkg::CMD_UP) begin
                  data0_in = tadc_pkg::pen_data0(data0_ff, touch_ff, 1'b1);
                  data1_in = tadc_pkg::pen_data1(data1_ff, 1'b1);
               end
               state_in = tadc_pkg::ST_IDLE;
            end
         end

         default: state_in = tadc_pkg::ST_IDLE;
      endcase
   end

   // control state and architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tadc_pkg::ST_IDLE;
         width_ff      <= tadc_pkg::WidthReset;
         height_ff     <= tadc_pkg::HeightReset;
         control_ff    <= '0;
         touch_ff      <= '0;
         delay_ff      <= '0;
         data0_ff      <= tadc_pkg::UpFlag;
         data1_ff      <= tadc_pkg::UpFlag;
         sample_x_ff   <= '0;
         sample_y_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         control_ff    <= control_in;
         touch_ff      <= touch_in;
         delay_ff      <= delay_in;
         data0_ff      <= data0_in;
         data1_ff      <= data1_in;
         sample_x_ff   <= sample_x_in;
         sample_y_ff   <= sample_y_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // item payload and divider datapath
   always_ff @(posedge clock) begin
      cmd_ff            <= cmd_in;
      offset_ff         <= offset_in;
      wdata_ff          <= wdata_in;
      pen_x_ff          <= pen_x_in;
      pen_y_ff          <= pen_y_in;
      axis_ff           <= axis_in;
      num_ff            <= num_in;
      rem_ff            <= rem_in;
      step_ff           <= step_in;
      rsp_read_data_ff  <= rsp_read_data_in;
      rsp_touch_irq_ff  <= rsp_touch_irq_in;
      rsp_bad_access_ff <= rsp_bad_access_in;
   end

endmodule
